FILE: design/waypoint_ramp_dwell_setpoint_macros.svh
// Assertion macros shared by the waypoint setpoint RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef WAYPOINT_RAMP_DWELL_SETPOINT_MACROS_SVH
`define WAYPOINT_RAMP_DWELL_SETPOINT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WRDSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WRDSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wrdsp_pkg.sv
// Types and constants for the waypoint ramp/dwell setpoint generator.
// No dependencies; used by every module of the block.
`default_nettype none

package wrdsp_pkg;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] measured_pos;
        logic [15:0]        elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] setpoint_pos;
        logic [2:0]         segment_number;
        logic               ramping;
        logic               finished;
    } t_out_item;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic mul;
        logic dinit;
        logic diter;
        logic fin;
        logic push;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_div;
        logic last_iter;
    } t_dp_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_FIN,
        S_PUSH
    } t_state;

    localparam logic       CMD_RESTART = 1'b0;
    localparam logic       CMD_TICK    = 1'b1;

    localparam logic [2:0] SEG_FIRST = 3'd1;
    localparam logic [2:0] SEG_LAST  = 3'd4;
    localparam logic [2:0] SEG_DONE  = 3'd5;

    localparam logic [2:0] REG_RAMP_TIME  = 3'd0;
    localparam logic [2:0] REG_DWELL_TIME = 3'd1;
    localparam logic [2:0] REG_OFFSET_1   = 3'd2;
    localparam logic [2:0] REG_OFFSET_2   = 3'd3;
    localparam logic [2:0] REG_OFFSET_3   = 3'd4;

    localparam logic [23:0] RAMP_TIME_RST  = 24'd500000;
    localparam logic [23:0] DWELL_TIME_RST = 24'd500000;
    localparam logic [31:0] OFFSET_1_RST   = 32'd16384;
    localparam logic [31:0] OFFSET_2_RST   = 32'd32768;
    localparam logic [31:0] OFFSET_3_RST   = 32'd65536;

    localparam int          DIV_STEPS      = 32;

endpackage

`default_nettype wire

FILE: design/wrdsp_dp.sv
// Datapath: configuration registers, sequence state, multiplier, serial divider
// and result register. Depends on wrdsp_pkg; driven by wrdsp_ctrl.
`default_nettype none

module wrdsp_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire wrdsp_pkg::t_in_item i_in,
    input  wire wrdsp_pkg::t_dp_cmd i_cmd,
    output wrdsp_pkg::t_dp_stat     o_stat,
    output wrdsp_pkg::t_out_item    o_out
);

    // configuration
    logic [23:0] r_ramp, r_dwell;
    logic [31:0] r_off1, r_off2, r_off3;

    // sequence state
    logic [31:0] r_origin;
    logic        r_latched;
    logic [2:0]  r_seg;
    logic [25:0] r_phase;
    logic [31:0] r_target;
    logic        r_ramping;

    // working registers
    wrdsp_pkg::t_in_item  r_item;
    wrdsp_pkg::t_out_item r_out;
    logic [31:0] r_start;
    logic        r_neg;
    logic [31:0] r_mag;
    logic [23:0] r_mph;
    logic [55:0] r_prod;
    logic [24:0] r_rem;
    logic [31:0] r_nlo;
    logic [4:0]  r_cnt;

    logic [31:0] eff_origin, wp_start, wp_next;
    logic [25:0] ph_sum;
    logic [24:0] ramp_dwell;
    logic        in_seq, in_ramp, in_dwell;
    logic [32:0] diff, diff_abs;
    logic [57:0] n_num;
    logic [25:0] div_t;
    logic [24:0] div_d;
    logic        div_ge;

    always_comb begin
        eff_origin = r_latched ? r_origin : 32'(r_item.measured_pos);
        case (r_seg)
            3'd1: begin
                wp_start = eff_origin;
                wp_next  = eff_origin + r_off1;
            end
            3'd2: begin
                wp_start = eff_origin + r_off1;
                wp_next  = eff_origin + r_off2;
            end
            3'd3: begin
                wp_start = eff_origin + r_off2;
                wp_next  = eff_origin + r_off3;
            end
            3'd4: begin
                wp_start = eff_origin + r_off3;
                wp_next  = eff_origin;
            end
            default: begin
                wp_start = eff_origin;
                wp_next  = eff_origin;
            end
        endcase
        ph_sum     = r_phase + {10'd0, r_item.elapsed_us};
        ramp_dwell = {1'b0, r_ramp} + {1'b0, r_dwell};
        in_seq     = r_seg inside {[wrdsp_pkg::SEG_FIRST:wrdsp_pkg::SEG_LAST]};
        in_ramp    = ph_sum < {2'b00, r_ramp};
        in_dwell   = ph_sum < {1'b0, ramp_dwell};
        diff       = {wp_next[31], wp_next} - {wp_start[31], wp_start};
        diff_abs   = diff[32] ? (33'd0 - diff) : diff;
        n_num      = {1'b0, r_prod, 1'b0} + {34'd0, r_ramp};
        div_d      = {r_ramp, 1'b0};
        div_t      = {r_rem, r_nlo[31]};
        div_ge     = div_t >= {1'b0, div_d};
    end

    assign o_stat.need_div  = (r_item.cmd == wrdsp_pkg::CMD_TICK) && in_seq && in_ramp;
    assign o_stat.last_iter = r_cnt == 5'(wrdsp_pkg::DIV_STEPS - 1);
    assign o_out            = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp  <= wrdsp_pkg::RAMP_TIME_RST;
            r_dwell <= wrdsp_pkg::DWELL_TIME_RST;
            r_off1  <= wrdsp_pkg::OFFSET_1_RST;
            r_off2  <= wrdsp_pkg::OFFSET_2_RST;
            r_off3  <= wrdsp_pkg::OFFSET_3_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wrdsp_pkg::REG_RAMP_TIME:  r_ramp  <= i_cfg_data[23:0];
                wrdsp_pkg::REG_DWELL_TIME: r_dwell <= i_cfg_data[23:0];
                wrdsp_pkg::REG_OFFSET_1:   r_off1  <= i_cfg_data;
                wrdsp_pkg::REG_OFFSET_2:   r_off2  <= i_cfg_data;
                wrdsp_pkg::REG_OFFSET_3:   r_off3  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin  <= '0;
            r_latched <= 1'b0;
            r_seg     <= wrdsp_pkg::SEG_FIRST;
            r_phase   <= '0;
            r_target  <= '0;
            r_ramping <= 1'b0;
        end else if (i_cmd.step) begin
            r_ramping <= 1'b0;
            if (r_item.cmd == wrdsp_pkg::CMD_RESTART) begin
                r_latched <= 1'b0;
                r_seg     <= wrdsp_pkg::SEG_FIRST;
                r_phase   <= '0;
            end else begin
                if (!r_latched) begin
                    r_origin  <= eff_origin;
                    r_target  <= eff_origin;
                    r_latched <= 1'b1;
                end
                if (in_seq) begin
                    if (in_ramp) begin
                        r_phase   <= ph_sum;
                        r_ramping <= 1'b1;
                    end else if (in_dwell) begin
                        r_phase  <= ph_sum;
                        r_target <= wp_next;
                    end else begin
                        // drop any overshoot and move on
                        r_phase  <= '0;
                        r_target <= wp_next;
                        r_seg    <= r_seg + 3'd1;
                    end
                end
            end
        end else if (i_cmd.fin) begin
            r_target <= r_neg ? (r_start - r_nlo) : (r_start + r_nlo);
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        if (i_cmd.step) begin
            r_start <= wp_start;
            r_neg   <= diff[32];
            r_mag   <= diff_abs[31:0];
            r_mph   <= ph_sum[23:0];
        end
        if (i_cmd.mul) begin
            r_prod <= r_mag * r_mph;
        end
        if (i_cmd.dinit) begin
            r_rem <= n_num[56:32];
            r_nlo <= n_num[31:0];
            r_cnt <= '0;
        end else if (i_cmd.diter) begin
            r_rem <= div_ge ? 25'(div_t - {1'b0, div_d}) : div_t[24:0];
            r_nlo <= {r_nlo[30:0], div_ge};
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_cmd.push) begin
            r_out.setpoint_pos   <= r_target;
            r_out.segment_number <= r_seg;
            r_out.ramping        <= r_ramping;
            r_out.finished       <= r_seg == wrdsp_pkg::SEG_DONE;
        end
    end

endmodule

`default_nettype wire

FILE: design/wrdsp_ctrl.sv
// Controller: state machine sequencing step, multiply, divide and result push.
// Depends on wrdsp_pkg and waypoint_ramp_dwell_setpoint_macros.svh.
`default_nettype none
`include "waypoint_ramp_dwell_setpoint_macros.svh"

module wrdsp_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    input  wire wrdsp_pkg::t_dp_stat i_stat,
    output wrdsp_pkg::t_dp_cmd       o_cmd
);

    wrdsp_pkg::t_state r_state, n_state;
    logic              r_out_valid;
    logic              out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = r_state != wrdsp_pkg::S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrdsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            wrdsp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = wrdsp_pkg::S_STEP;
                end
            end
            wrdsp_pkg::S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = i_stat.need_div ? wrdsp_pkg::S_MUL : wrdsp_pkg::S_PUSH;
            end
            wrdsp_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = wrdsp_pkg::S_DINIT;
            end
            wrdsp_pkg::S_DINIT: begin
                o_cmd.dinit = 1'b1;
                n_state     = wrdsp_pkg::S_DIV;
            end
            wrdsp_pkg::S_DIV: begin
                o_cmd.diter = 1'b1;
                if (i_stat.last_iter) begin
                    n_state = wrdsp_pkg::S_FIN;
                end
            end
            wrdsp_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = wrdsp_pkg::S_PUSH;
            end
            wrdsp_pkg::S_PUSH: begin
                if (out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = wrdsp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wrdsp_pkg::S_IDLE;
            end
        endcase
    end

    `WRDSP_ASSERT_NOW(a_push_free, o_cmd.push, !r_out_valid || !i_out_stall, "push into a full result register")
    `WRDSP_ASSERT_NEXT(a_accept_steps, (r_state == wrdsp_pkg::S_IDLE) && i_in_valid, r_state == wrdsp_pkg::S_STEP, "accepted request did not step")
    `WRDSP_ASSERT_NEXT(a_div_ends, (r_state == wrdsp_pkg::S_DIV) && i_stat.last_iter, r_state == wrdsp_pkg::S_FIN, "divider did not finish")
    `WRDSP_ASSERT_NEXT(a_push_shows, o_cmd.push, r_out_valid && (r_state == wrdsp_pkg::S_IDLE), "pushed result not presented")

endmodule

`default_nettype wire

FILE: design/waypoint_ramp_dwell_setpoint.sv
// Top level of the waypoint ramp/dwell position setpoint generator.
// Depends on wrdsp_pkg, wrdsp_ctrl and wrdsp_dp.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------
//  in      | in        | i_in_valid / o_in_stall  | i_in  (t_in_item)
//  out     | out       | o_out_valid / i_out_stall| o_out (t_out_item)
//  cfg     | in        | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// A request is taken only while the controller is idle. A tick that lands
// inside a ramp passes from acceptance to result through a step, a multiply,
// a divider load, the radix-2 restoring divider, forming the target and a
// push; any other request goes through step and push only. The controller
// returns to idle after the push, and only then takes the next request.
// Reset is synchronous and active low; it restores the register defaults and
// the sequence state (segment one, no origin held, target zero).
// A stalled result waits in the output register; the next request is still
// accepted and is held back only when its own result is ready to be pushed.
`default_nettype none

module waypoint_ramp_dwell_setpoint (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire wrdsp_pkg::t_in_item  i_in,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output wrdsp_pkg::t_out_item      o_out,
    // configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    wrdsp_pkg::t_dp_cmd  dp_cmd;
    wrdsp_pkg::t_dp_stat dp_stat;

    // sequence the work for each request
    wrdsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // hold the registers, waypoints, phase and the interpolation arithmetic
    wrdsp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
